[hdl/stssc_pkg.sv]
package stssc_pkg;

    // Field and register widths.
    localparam int DataW  = 32;
    localparam int LenW   = 7;
    localparam int IdxW   = 6;
    localparam int CountW = 7;
    localparam int CfgIdxW = 1;

    // Default table depth.
    localparam int DefaultDepth = 64;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Search mode codes.
    localparam logic MODE_BINARY = 1'b0;
    localparam logic MODE_INTERP = 1'b1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_LENGTH = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_MODE   = 1'b1;

endpackage

[hdl/stssc_mem.sv]
module stssc_mem #(
    parameter int TABLE_DEPTH = stssc_pkg::DefaultDepth,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic signed [stssc_pkg::DataW-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic signed [stssc_pkg::DataW-1:0] rd_data
);
    import stssc_pkg::*;

    logic signed [DataW-1:0] mem [TABLE_DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/stssc_div.sv]
module stssc_div #(
    parameter int AW = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [AW+stssc_pkg::DataW-1:0]  dividend,
    input  logic [stssc_pkg::DataW-1:0]     divisor,
    output logic                            done,
    output logic [AW-1:0]                   quotient
);
    import stssc_pkg::*;

    localparam int DW = AW + DataW;
    localparam int CW = $clog2(AW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsh_reg, dsh_next;
    logic [AW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          fits;

    // Restoring division, one quotient bit per cycle. The quotient is known
    // to fit in AW bits because the offset never exceeds the span.
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        fits      = rem_reg >= dsh_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsh_next  = DW'(divisor) << (AW - 1);
            q_next    = '0;
            cnt_next  = CW'(AW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = AW'({q_reg, fits});
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[hdl/sorted_table_search_step_counter.sv]
// Channel   Handshake            Payload
// input     in_valid/in_ready    operation, entry_index, data_value
// output    out_valid/out_ready  key_found, probe_count
// config    cfg_wr_en            cfg_index, cfg_data
//
// A load is written to the table as it is taken. A binary probe passes
// through the check and compare states; an interpolation probe reads both
// end values, runs the serial divider and reads the middle entry, skipping
// the divider when both end values are equal. All use the single read port.
// One search is worked on at a time; loads are taken while a result waits.
// Reset is asynchronous and clears control state; the table is not cleared.
module sorted_table_search_step_counter #(
    parameter int TABLE_DEPTH = stssc_pkg::DefaultDepth
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [stssc_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [stssc_pkg::LenW-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [stssc_pkg::IdxW-1:0]         entry_index,
    input  logic signed [stssc_pkg::DataW-1:0] data_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               key_found,
    output logic [stssc_pkg::CountW-1:0]       probe_count
);
    import stssc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = AW + 1;
    localparam int LastTop = (TABLE_DEPTH - 1) / 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_LO     = 4'd3;
    localparam logic [3:0] S_HI     = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_RDMID  = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [LenW-1:0]         len_reg, len_next;
    logic                    mode_reg, mode_next;
    logic signed [IW-1:0]    low_reg, low_next;
    logic signed [IW-1:0]    high_reg, high_next;
    logic signed [IW-1:0]    mid_reg, mid_next;
    logic signed [DataW-1:0] key_reg, key_next;
    logic signed [DataW-1:0] lo_v_reg, lo_v_next;
    logic signed [DataW-1:0] hi_v_reg;
    logic [CountW-1:0]       count_reg, count_next;
    logic                    found_reg, found_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    key_found_reg, key_found_next;
    logic [CountW-1:0]       probe_count_reg, probe_count_next;

    logic                    mem_we;
    logic [AW-1:0]           mem_raddr;
    logic signed [DataW-1:0] mem_rdata;
    logic                    div_start;
    logic                    div_done;
    logic [AW-1:0]           div_q;
    logic [AW+DataW-1:0]     dividend;
    logic [DataW-1:0]        divisor;
    logic [DataW:0]          num_wide;
    logic [DataW:0]          den_hold;
    logic [IW-1:0]           span;
    logic signed [IW-1:0]    last_idx;
    logic [IW:0]             mid_sum;
    logic signed [IW-1:0]    mid_bin;
    logic                    in_xfer;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign mem_we   = in_xfer && (operation == OP_LOAD)
                      && (32'(entry_index) < 32'(TABLE_DEPTH));

    // Highest searched index from the clamped length.
    always_comb
    begin
        if (32'(len_reg) > 32'(TABLE_DEPTH))
        begin
            last_idx = IW'(LastTop);
        end
        else if (len_reg == '0)
        begin
            last_idx = '0;
        end
        else
        begin
            last_idx = IW'((len_reg - 1'b1) >> 1);
        end
    end

    // Binary midpoint; both bounds are non-negative whenever it is used.
    assign mid_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_bin = IW'(mid_sum >> 1);

    // Interpolation operands: span * (key - lo) over (hi - lo).
    assign span     = high_reg - low_reg;
    assign num_wide = {key_reg[DataW-1], key_reg} - {lo_v_reg[DataW-1], lo_v_reg};
    assign den_hold = {hi_v_reg[DataW-1], hi_v_reg} - {lo_v_reg[DataW-1], lo_v_reg};
    assign dividend = (AW + DataW)'(span[AW-1:0]) * (AW + DataW)'(num_wide[DataW-1:0]);
    assign divisor  = den_hold[DataW-1:0];

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        mode_next        = mode_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        lo_v_next        = lo_v_reg;
        count_next       = count_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg;
        key_found_next   = key_found_reg;
        probe_count_next = probe_count_reg;
        mem_raddr        = mid_reg[AW-1:0];
        div_start        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LENGTH: len_next  = cfg_data;
                REG_MODE:   mode_next = cfg_data[0];
                default:    len_next  = len_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (operation == OP_SEARCH))
                begin
                    key_next   = data_value;
                    low_next   = '0;
                    high_next  = last_idx;
                    count_next = '0;
                    found_next = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (low_reg > high_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (mode_reg == MODE_BINARY)
                begin
                    mem_raddr  = mid_bin[AW-1:0];
                    mid_next   = mid_bin;
                    count_next = count_reg + 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    mem_raddr  = low_reg[AW-1:0];
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                lo_v_next  = mem_rdata;
                mem_raddr  = high_reg[AW-1:0];
                state_next = S_HI;
            end
            S_HI:
            begin
                if ((key_reg < lo_v_reg) || (key_reg > mem_rdata))
                begin
                    count_next = CountW'(1);
                    found_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if (low_reg == high_reg)
                begin
                    found_next = (key_reg == mem_rdata);
                    state_next = S_FINISH;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    if (mem_rdata == lo_v_reg)
                    begin
                        mid_next   = low_reg;
                        state_next = S_RDMID;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mid_next   = low_reg + IW'(div_q);
                    state_next = S_RDMID;
                end
            end
            S_RDMID:
            begin
                mem_raddr  = mid_reg[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_reg == mem_rdata)
                begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end
                else if (key_reg < mem_rdata)
                begin
                    high_next  = mid_reg - 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    low_next   = mid_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    key_found_next   = found_reg;
                    probe_count_next = count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Keep the high entry for the divider, since the read port moves on.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_HI)
        begin
            hi_v_reg <= mem_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LenW'(1);
            mode_reg      <= MODE_BINARY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg         <= low_next;
        high_reg        <= high_next;
        mid_reg         <= mid_next;
        key_reg         <= key_next;
        lo_v_reg        <= lo_v_next;
        count_reg       <= count_next;
        found_reg       <= found_next;
        key_found_reg   <= key_found_next;
        probe_count_reg <= probe_count_next;
    end

    stssc_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (AW'(entry_index)),
        .wr_data (data_value),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    stssc_div #(
        .AW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid   = out_valid_reg;
    assign key_found   = key_found_reg;
    assign probe_count = probe_count_reg;

endmodule

[tb/sv/stssc_result_checker.sv]
module stssc_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [stssc_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [stssc_pkg::LenW-1:0]          cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                operation,
    input  logic [stssc_pkg::IdxW-1:0]          entry_index,
    input  logic signed [stssc_pkg::DataW-1:0]  data_value,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                key_found,
    input  logic [stssc_pkg::CountW-1:0]        probe_count,
    output int                                  mismatch_count,
    output int                                  results_pending
);
    import stssc_pkg::*;

    typedef struct packed {
        logic              found;
        logic [CountW-1:0] count;
    } search_result_t;

    // Shadow copy of the table and the registers.
    logic signed [DataW-1:0] table_copy [DefaultDepth];
    logic [LenW-1:0]         length_reg;
    logic                    mode_reg;
    search_result_t          expected_results [$];

    // Works out the outcome of one search on the current table copy.
    function automatic search_result_t predict_search(input logic signed [DataW-1:0] key);
        search_result_t res;
        int     n;
        int     lo;
        int     hi;
        int     mid;
        int     steps;
        longint lv;
        longint hv;
        longint span;
        longint num;
        longint den;
        longint off;
        n = length_reg;
        if (n < 1)
            n = 1;
        if (n > DefaultDepth)
            n = DefaultDepth;
        lo = 0;
        hi = (n - 1) / 2;
        steps = 0;
        res.found = 1'b0;
        if (mode_reg == MODE_BINARY)
        begin
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                steps++;
                if (key == table_copy[mid])
                begin
                    res.found = 1'b1;
                    break;
                end
                else if (key < table_copy[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        else
        begin
            while (lo <= hi)
            begin
                lv = table_copy[lo];
                hv = table_copy[hi];
                // A key outside the end values stops the search at once.
                if (longint'(key) < lv || longint'(key) > hv)
                begin
                    steps = 1;
                    break;
                end
                // A single element is compared without counting a step.
                if (lo == hi)
                begin
                    res.found = (longint'(key) == hv);
                    break;
                end
                steps++;
                if (hv == lv)
                    mid = lo;
                else
                begin
                    span = hi - lo;
                    num = longint'(key) - lv;
                    den = hv - lv;
                    off = (span * num) / den;
                    if (off > span)
                        off = span;
                    mid = lo + int'(off);
                end
                if (key == table_copy[mid])
                begin
                    res.found = 1'b1;
                    break;
                end
                else if (key < table_copy[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        res.count = steps[CountW-1:0];
        return res;
    endfunction

    // Track register writes, input transfers and output transfers.
    always @(posedge clk or negedge rst_n)
    begin
        search_result_t exp_res;
        if (!rst_n)
        begin
            length_reg = 7'd1;
            mode_reg = MODE_BINARY;
            mismatch_count = 0;
            expected_results.delete();
            results_pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_LENGTH)
                    length_reg = cfg_data;
                else if (cfg_index == REG_MODE)
                    mode_reg = cfg_data[0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result transfer with nothing expected: found=%0d count=%0d",
                                 key_found, probe_count);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (key_found !== exp_res.found || probe_count !== exp_res.count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: found exp %0d got %0d, count exp %0d got %0d",
                                     exp_res.found, key_found, exp_res.count, probe_count);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD)
                    table_copy[entry_index] = data_value;
                else
                    expected_results.push_back(predict_search(data_value));
            end
            results_pending = expected_results.size();
        end
    end

endmodule

[tb/sv/tb_sorted_table_search_step_counter.sv]
module tb_sorted_table_search_step_counter;
    import stssc_pkg::*;

    localparam int CycleLimit = 1500000;
    localparam int RandomItems = 720;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CfgIdxW-1:0]      cfg_index;
    logic [LenW-1:0]         cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    operation;
    logic [IdxW-1:0]         entry_index;
    logic signed [DataW-1:0] data_value;
    logic                    out_valid;
    logic                    out_ready;
    logic                    key_found;
    logic [CountW-1:0]       probe_count;
    int                      mismatch_count;
    int                      results_pending;

    int                      send_idle;
    int                      recv_idle;
    int                      items_sent;
    int                      searches_sent;
    int                      settings_used;
    int                      cycle_count;
    logic signed [DataW-1:0] shadow [DefaultDepth];

    sorted_table_search_step_counter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .entry_index (entry_index),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_found   (key_found),
        .probe_count (probe_count)
    );

    stssc_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .entry_index     (entry_index),
        .data_value      (data_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .key_found       (key_found),
        .probe_count     (probe_count),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one item and waits for its transfer, with random gaps first.
    task automatic push_item(input logic op, input logic [IdxW-1:0] idx,
                             input logic signed [DataW-1:0] val);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        entry_index <= idx;
        data_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (op == OP_SEARCH)
            searches_sent++;
        else
            shadow[idx] = val;
    endtask

    // Writes one register once the block has drained.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_search(input logic [LenW-1:0] len, input logic mode);
        write_reg(REG_LENGTH, len);
        write_reg(REG_MODE, {6'd0, mode});
        settings_used++;
    endtask

    // Loads entries 0..last in one of several shapes.
    task automatic fill_table(input int last);
        longint cur;
        longint step_max;
        int     shape;
        shape = $urandom_range(9);
        step_max = (shape < 4) ? 16 : (shape < 7) ? 4096 : (shape < 8) ? 0 : 134217728;
        cur = longint'($signed($urandom())) / ((shape < 7) ? 4 : 1);
        if (shape == 8)
            cur = -longint'(32'h80000000) + $urandom_range(1000);
        for (int i = 0; i <= last; i++)
        begin
            if (shape == 9)
                push_item(OP_LOAD, i[IdxW-1:0], $urandom());
            else
            begin
                if (cur > 2147483647)
                    cur = 2147483647;
                push_item(OP_LOAD, i[IdxW-1:0], cur[DataW-1:0]);
                cur = cur + longint'($urandom_range(step_max));
            end
        end
    endtask

    // Chooses a key near the table contents most of the time.
    function automatic logic signed [DataW-1:0] pick_key(input int last);
        logic signed [DataW-1:0] k;
        k = shadow[$urandom_range(last)];
        case ($urandom_range(9))
            4: k = k + 1;
            5: k = k - 1;
            6: k = $urandom();
            7: k = 32'sh80000000;
            8: k = 32'sh7fffffff;
            9: k = shadow[0] - 1;
            default: ;
        endcase
        return k;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int last;
        int len;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_LENGTH;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        entry_index = '0;
        data_value = '0;
        out_ready = 1'b0;
        cycle_count = 0;
        send_idle = 16;
        recv_idle = 50;
        items_sent = 0;
        searches_sent = 0;
        settings_used = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: write every entry, extremes at the ends of the range.
        for (int i = 0; i < DefaultDepth; i++)
            push_item(OP_LOAD, i[IdxW-1:0], i * 1000 - 20000);
        push_item(OP_LOAD, 6'd0, 32'sh80000000);
        push_item(OP_LOAD, 6'd31, 32'sh7fffffff);
        set_search(7'd64, MODE_BINARY);
        push_item(OP_SEARCH, 6'd0, 32'sh80000000);
        push_item(OP_SEARCH, 6'd63, 32'sh7fffffff);
        push_item(OP_SEARCH, 6'd0, shadow[15]);
        push_item(OP_SEARCH, 6'd0, shadow[15] + 1);
        set_search(7'd64, MODE_INTERP);
        push_item(OP_SEARCH, 6'd0, 32'sh80000000);
        push_item(OP_SEARCH, 6'd0, 32'sh7fffffff);
        push_item(OP_SEARCH, 6'd0, shadow[7]);
        push_item(OP_SEARCH, 6'd0, shadow[7] + 1);
        // Key outside the end values of a shorter range.
        set_search(7'd20, MODE_INTERP);
        push_item(OP_SEARCH, 6'd0, 32'sh7fffffff);
        // A single element, both methods.
        set_search(7'd1, MODE_INTERP);
        push_item(OP_SEARCH, 6'd0, shadow[0]);
        push_item(OP_SEARCH, 6'd0, 32'sd5);
        set_search(7'd0, MODE_BINARY);
        push_item(OP_SEARCH, 6'd0, shadow[0]);
        // Equal end values give a zero denominator.
        for (int i = 0; i < 4; i++)
            push_item(OP_LOAD, i[IdxW-1:0], 32'sd5);
        set_search(7'd7, MODE_INTERP);
        push_item(OP_SEARCH, 6'd0, 32'sd5);
        push_item(OP_SEARCH, 6'd0, 32'sd4);
        push_item(OP_SEARCH, 6'd0, 32'sd6);
        // Lengths above the table depth.
        set_search(7'd127, MODE_BINARY);
        push_item(OP_SEARCH, 6'd0, shadow[31]);
        set_search(7'd127, MODE_INTERP);
        push_item(OP_SEARCH, 6'd0, shadow[20]);

        // Random part: rounds of setting, table load and searches.
        items_sent = 0;
        while (items_sent < RandomItems)
        begin
            if (items_sent < RandomItems / 3)
            begin
                send_idle = 16;
                recv_idle = 50;
            end
            else if (items_sent < 2 * RandomItems / 3)
            begin
                send_idle = 50;
                recv_idle = 16;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case ($urandom_range(7))
                0: len = 1;
                1: len = 64;
                2: len = 2;
                3: len = 127;
                4: len = 0;
                default: len = $urandom_range(64, 1);
            endcase
            last = (len < 1) ? 0 : (len > DefaultDepth) ? 31 : (len - 1) / 2;
            set_search(len[LenW-1:0], 1'($urandom_range(1)));
            fill_table(last);
            repeat ($urandom_range(20, 8))
            begin
                // Occasional stray load anywhere in the table.
                if ($urandom_range(9) == 0)
                    push_item(OP_LOAD, IdxW'($urandom_range(63)), $urandom());
                else
                    push_item(OP_SEARCH, IdxW'($urandom_range(63)), pick_key(last));
            end
        end

        // Drain the remaining results.
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Ran %0d searches over %0d register settings, both methods, in %0d cycles.",
                 searches_sent, settings_used, cycle_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
